// ----- rtl/core/bgu2x_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bgu2x_pkg;

    // Grid limits and field widths.
    localparam int MAX_COLUMNS    = 1024;
    localparam int MAX_ROWS       = 1024;
    localparam int SAMPLE_BITS    = 32;
    localparam int VALUE_BITS     = SAMPLE_BITS + 2;
    localparam int COL_BITS       = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS       = $clog2(MAX_ROWS);
    localparam int SIZE_BITS      = 11;
    localparam int COORD_BITS     = 11;
    localparam int CFG_INDEX_BITS = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GRID_COLUMNS = 2'd0,
        REG_GRID_ROWS    = 2'd1
    } cfg_reg_t;

    // Saturate a programmed grid size into the range [2, hi].
    function automatic logic [SIZE_BITS-1:0] clamp_size(
        input logic [SIZE_BITS-1:0] v,
        input logic [SIZE_BITS-1:0] hi
    );
        logic [SIZE_BITS-1:0] r;
        begin
            if (v < SIZE_BITS'(2))
            begin
                r = SIZE_BITS'(2);
            end
            else if (v > hi)
            begin
                r = hi;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bilinear_grid_upsample_2x_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+---------------------------------------
// sample    | in        | sample_valid/sample_stall | sample, grid_start
// result    | out       | result_valid/result_stall | out_column, out_row, value, last
// cfg       | in        | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// An input beat produces one to four result beats, one per cycle while result_stall is low,
// so an interior sample yields four beats; edge samples yield one or two.
// The line buffer is read and written in the cycle a sample beat is taken; the values
// are then formed from stage one and enter the result buffer once that buffer is free.
// Reset clears the grid position, the held neighbor samples and sets both sizes to 1024.
// A stall on the result channel backs up into sample_stall after one held sample.

module bilinear_grid_upsample_2x_unit
    import bgu2x_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Sample channel.
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          grid_start,
    // Result channel.
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [COORD_BITS-1:0]              out_column,
    output logic [COORD_BITS-1:0]              out_row,
    output logic signed [VALUE_BITS-1:0]       value,
    output logic                               last,
    // Configuration channel.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [SIZE_BITS-1:0]          cfg_data
);

    // Which of the four points of a sample is on the output.
    typedef enum logic [1:0] {
        K_SAMPLE = 2'd0,
        K_HORIZ  = 2'd1,
        K_VERT   = 2'd2,
        K_CENTER = 2'd3
    } kind_t;

    // Configuration registers.
    logic [SIZE_BITS-1:0] grid_columns_reg;
    logic [SIZE_BITS-1:0] grid_rows_reg;

    // Position and neighbor state.
    logic [COL_BITS-1:0]          column_count_reg;
    logic [ROW_BITS-1:0]          row_count_reg;
    logic signed [SAMPLE_BITS-1:0] left_sample_reg;
    logic signed [SAMPLE_BITS-1:0] upper_left_reg;

    // Line buffer.
    logic signed [SAMPLE_BITS-1:0] row_buffer [MAX_COLUMNS];
    logic signed [SAMPLE_BITS-1:0] above_reg;

    // Stage one: sample waiting for its line buffer data.
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic signed [SAMPLE_BITS-1:0] s1_left_reg;
    logic [COL_BITS-1:0]           s1_col_reg;
    logic [ROW_BITS-1:0]           s1_row_reg;

    // Result buffer.
    logic                          buf_valid_reg;
    kind_t                         kind_reg;
    kind_t                         kind_next;
    logic                          kind_done;
    logic [COL_BITS-1:0]           buf_col_reg;
    logic [ROW_BITS-1:0]           buf_row_reg;
    logic                          buf_hz_reg;
    logic                          buf_vt_reg;
    logic signed [VALUE_BITS-1:0]  val_reg [4];

    logic                          in_take;
    logic                          out_take;
    logic                          buf_free;
    logic                          s1_move;
    logic [COL_BITS-1:0]           cur_col;
    logic [ROW_BITS-1:0]           cur_row;
    logic [SIZE_BITS-1:0]          eff_cols;
    logic [SIZE_BITS-1:0]          eff_rows;
    logic [SIZE_BITS-1:0]          col_inc;
    logic [SIZE_BITS-1:0]          row_inc;
    logic signed [VALUE_BITS-1:0]  v_sample;
    logic signed [VALUE_BITS-1:0]  v_horiz;
    logic signed [VALUE_BITS-1:0]  v_vert;
    logic signed [VALUE_BITS-1:0]  v_center;
    logic signed [SAMPLE_BITS:0]   sum_left;
    logic signed [SAMPLE_BITS:0]   sum_above;
    logic [COORD_BITS-1:0]         col2;
    logic [COORD_BITS-1:0]         row2;

    // Handshake decisions.
    assign cfg_ready    = 1'b1;
    assign out_take     = buf_valid_reg && !result_stall;
    assign buf_free     = !buf_valid_reg || (out_take && kind_done);
    assign s1_move      = s1_valid_reg && buf_free;
    assign sample_stall = s1_valid_reg && !buf_free;
    assign in_take      = sample_valid && !sample_stall;

    // Position of the incoming sample and the next position.
    always_comb
    begin
        eff_cols = clamp_size(grid_columns_reg, SIZE_BITS'(MAX_COLUMNS));
        eff_rows = clamp_size(grid_rows_reg, SIZE_BITS'(MAX_ROWS));
        cur_col  = grid_start ? '0 : column_count_reg;
        cur_row  = grid_start ? '0 : row_count_reg;
        col_inc  = SIZE_BITS'(cur_col) + SIZE_BITS'(1);
        row_inc  = SIZE_BITS'(cur_row) + SIZE_BITS'(1);
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= SIZE_BITS'(1024);
            grid_rows_reg    <= SIZE_BITS'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_COLUMNS: grid_columns_reg <= cfg_data;
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Line buffer: read the sample above and store the new one in the same edge.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            above_reg           <= row_buffer[cur_col];
            row_buffer[cur_col] <= sample;
        end
    end

    // Position counters and the left neighbor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            left_sample_reg  <= '0;
        end
        else if (in_take)
        begin
            left_sample_reg <= sample;
            if (col_inc >= eff_cols)
            begin
                column_count_reg <= '0;
                row_count_reg    <= (row_inc >= eff_rows) ? '0 : ROW_BITS'(row_inc);
            end
            else
            begin
                column_count_reg <= COL_BITS'(col_inc);
                row_count_reg    <= cur_row;
            end
        end
    end

    // Stage one registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= sample;
            s1_left_reg   <= left_sample_reg;
            s1_col_reg    <= cur_col;
            s1_row_reg    <= cur_row;
        end
    end

    // The four interpolated values, in quarter LSB units.
    always_comb
    begin
        sum_left  = (SAMPLE_BITS + 1)'(s1_left_reg) + (SAMPLE_BITS + 1)'(s1_sample_reg);
        sum_above = (SAMPLE_BITS + 1)'(above_reg) + (SAMPLE_BITS + 1)'(s1_sample_reg);
        v_sample  = {s1_sample_reg, 2'b00};
        v_horiz   = {sum_left, 1'b0};
        v_vert    = {sum_above, 1'b0};
        v_center  = VALUE_BITS'(sum_left) + VALUE_BITS'(above_reg)
                  + VALUE_BITS'(upper_left_reg);
    end

    // The upper-left neighbor is the line buffer word of the previous sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_left_reg <= '0;
        end
        else if (s1_move)
        begin
            upper_left_reg <= above_reg;
        end
    end

    // Result buffer payload.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            buf_col_reg <= s1_col_reg;
            buf_row_reg <= s1_row_reg;
            buf_hz_reg  <= (s1_col_reg != '0);
            buf_vt_reg  <= (s1_row_reg != '0);
            val_reg[0]  <= v_sample;
            val_reg[1]  <= v_horiz;
            val_reg[2]  <= v_vert;
            val_reg[3]  <= v_center;
        end
    end

    // Point sequence: sample, horizontal, vertical, center, skipping those at an edge.
    always_comb
    begin
        kind_next = K_SAMPLE;
        kind_done = 1'b1;
        unique case (kind_reg)
            K_SAMPLE:
            begin
                if (buf_hz_reg)
                begin
                    kind_next = K_HORIZ;
                    kind_done = 1'b0;
                end
                else if (buf_vt_reg)
                begin
                    kind_next = K_VERT;
                    kind_done = 1'b0;
                end
            end
            K_HORIZ:
            begin
                if (buf_vt_reg)
                begin
                    kind_next = K_VERT;
                    kind_done = 1'b0;
                end
            end
            K_VERT:
            begin
                if (buf_hz_reg)
                begin
                    kind_next = K_CENTER;
                    kind_done = 1'b0;
                end
            end
            K_CENTER:
            begin
                kind_done = 1'b1;
            end
            default:
            begin
                kind_done = 1'b1;
            end
        endcase
    end

    // Result sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            kind_reg      <= K_SAMPLE;
        end
        else if (s1_move)
        begin
            buf_valid_reg <= 1'b1;
            kind_reg      <= K_SAMPLE;
        end
        else if (out_take)
        begin
            if (kind_done)
            begin
                buf_valid_reg <= 1'b0;
                kind_reg      <= K_SAMPLE;
            end
            else
            begin
                kind_reg <= kind_next;
            end
        end
    end

    // Result payload.
    always_comb
    begin
        col2         = {buf_col_reg, 1'b0};
        row2         = {buf_row_reg, 1'b0};
        result_valid = buf_valid_reg;
        last         = kind_done;
        value        = val_reg[kind_reg];
        out_column   = (kind_reg == K_HORIZ || kind_reg == K_CENTER)
                     ? col2 - COORD_BITS'(1) : col2;
        out_row      = (kind_reg == K_VERT || kind_reg == K_CENTER)
                     ? row2 - COORD_BITS'(1) : row2;
    end

    // A full stage one that cannot drain must hold off new samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !buf_free) |-> sample_stall)
        else $error("sample taken while stage one is blocked");

    // The sample point sits on even coordinates, the center point on odd ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind_reg == K_SAMPLE) |-> (!out_column[0] && !out_row[0]))
        else $error("sample point on odd coordinates");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind_reg == K_CENTER) |-> (out_column[0] && out_row[0] && last))
        else $error("center point misplaced or not last");

    // After the last beat of a sample, the next beat starts a new sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && last) |=> (!result_valid || kind_reg == K_SAMPLE))
        else $error("result sequence did not restart");

endmodule

`default_nettype wire

// ----- tb/sv/bgu2x_checker.sv -----
`timescale 1ns / 1ps

// Watches the sample, configuration and result channels of the upsampler.
// Every accepted sample beat is run through a behavioral copy of the grid walk.
// Each accepted result beat is then matched in order against the points that are still due.
module bgu2x_checker
    import bgu2x_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    input  wire logic                          sample_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          grid_start,
    input  wire logic                          result_valid,
    input  wire logic                          result_stall,
    input  wire logic [COORD_BITS-1:0]         out_column,
    input  wire logic [COORD_BITS-1:0]         out_row,
    input  wire logic signed [VALUE_BITS-1:0]  value,
    input  wire logic                          last,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [SIZE_BITS-1:0]          cfg_data,
    output int                                 mismatch_count,
    output int                                 outstanding
);

    typedef struct packed {
        logic [COORD_BITS-1:0]        column;
        logic [COORD_BITS-1:0]        row;
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
    } grid_point_t;

    // Points still owed by the block, oldest first.
    grid_point_t expected_points[$];

    // Shadow of the grid walk: previous row, left neighbor, position and sizes.
    logic signed [SAMPLE_BITS-1:0] line_store [MAX_COLUMNS];
    logic signed [SAMPLE_BITS-1:0] prev_sample;
    logic signed [SAMPLE_BITS-1:0] prev_above;
    int                            col_pos;
    int                            row_pos;
    logic [SIZE_BITS-1:0]          columns_reg;
    logic [SIZE_BITS-1:0]          rows_reg;

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    function automatic logic signed [VALUE_BITS-1:0] widen(
        input logic signed [SAMPLE_BITS-1:0] x
    );
        return {{(VALUE_BITS-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
    endfunction

    function automatic grid_point_t make_point(input int col, input int row,
                                               input logic signed [VALUE_BITS-1:0] v);
        grid_point_t p;
        p.column = COORD_BITS'(col);
        p.row    = COORD_BITS'(row);
        p.value  = v;
        p.last   = 1'b0;
        return p;
    endfunction

    // Work out the one to four interpolated points that a sample beat produces.
    task automatic predict_points(input logic signed [SAMPLE_BITS-1:0] s, input logic gs);
        logic signed [SAMPLE_BITS-1:0] above;
        logic signed [VALUE_BITS-1:0]  s_w;
        logic signed [VALUE_BITS-1:0]  left_w;
        logic signed [VALUE_BITS-1:0]  above_w;
        logic signed [VALUE_BITS-1:0]  corner_w;
        grid_point_t                   pts [4];
        int                            n;
        int                            cols;
        int                            rows;
        begin
            // Programmed sizes outside the legal range saturate.
            cols = (columns_reg < 2) ? 2 :
                   ((columns_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(columns_reg));
            rows = (rows_reg < 2) ? 2 :
                   ((rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg));
            if (gs)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            above    = line_store[col_pos];
            s_w      = widen(s);
            left_w   = widen(prev_sample);
            above_w  = widen(above);
            corner_w = widen(prev_above);

            n = 0;
            pts[n] = make_point(2 * col_pos, 2 * row_pos, s_w <<< 2);
            n = n + 1;
            if (col_pos > 0)
            begin
                pts[n] = make_point(2 * col_pos - 1, 2 * row_pos, (left_w + s_w) <<< 1);
                n = n + 1;
            end
            if (row_pos > 0)
            begin
                pts[n] = make_point(2 * col_pos, 2 * row_pos - 1, (above_w + s_w) <<< 1);
                n = n + 1;
            end
            if (col_pos > 0 && row_pos > 0)
            begin
                pts[n] = make_point(2 * col_pos - 1, 2 * row_pos - 1,
                                    corner_w + above_w + left_w + s_w);
                n = n + 1;
            end
            pts[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                expected_points.push_back(pts[i]);
            end

            line_store[col_pos] = s;
            prev_above          = above;
            prev_sample         = s;

            // Advance the raster position; a held position past a shrunk size wraps here.
            col_pos = col_pos + 1;
            if (col_pos >= cols)
            begin
                col_pos = 0;
                row_pos = row_pos + 1;
                if (row_pos >= rows)
                begin
                    row_pos = 0;
                end
            end
        end
    endtask

    // Compare one result beat with the oldest point that is due.
    task automatic check_point();
        grid_point_t want;
        begin
            if (expected_points.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("ERROR %0t: result beat with none due: col %0d row %0d value %0d last %0b",
                             $realtime, out_column, out_row, value, last);
                end
            end
            else
            begin
                want = expected_points.pop_front();
                if (want.column !== out_column || want.row !== out_row ||
                    want.value !== value || want.last !== last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("ERROR %0t: expected col %0d row %0d value %0d last %0b",
                                 $realtime, want.column, want.row, want.value, want.last);
                        $display("ERROR %0t: got      col %0d row %0d value %0d last %0b",
                                 $realtime, out_column, out_row, value, last);
                    end
                end
            end
        end
    endtask

    // Beats on all three channels are taken at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_COLUMNS; i++)
            begin
                line_store[i] = '0;
            end
            prev_sample = '0;
            prev_above  = '0;
            col_pos     = 0;
            row_pos     = 0;
            columns_reg = SIZE_BITS'(MAX_COLUMNS);
            rows_reg    = SIZE_BITS'(MAX_ROWS);
            expected_points.delete();
            outstanding = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                check_point();
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_GRID_COLUMNS: columns_reg = cfg_data;
                    REG_GRID_ROWS:    rows_reg = cfg_data;
                    default:          ;
                endcase
            end
            if (sample_valid && !sample_stall)
            begin
                predict_points(sample, grid_start);
            end
            outstanding = expected_points.size();
        end
    end

endmodule

// ----- tb/sv/tb_bilinear_grid_upsample_2x_unit.sv -----
`timescale 1ns / 1ps

module tb_bilinear_grid_upsample_2x_unit;
    import bgu2x_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 32'sh8000_0000;
    // An index with no register behind it; a write there must leave both sizes alone.
    localparam logic [CFG_INDEX_BITS-1:0]     UNUSED_REG_INDEX = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          sample_valid;
    logic                          sample_stall;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          grid_start;
    logic                          result_valid;
    logic                          result_stall;
    logic [COORD_BITS-1:0]         out_column;
    logic [COORD_BITS-1:0]         out_row;
    logic signed [VALUE_BITS-1:0]  value;
    logic                          last;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [SIZE_BITS-1:0]          cfg_data;
    int                            mismatch_count;
    int                            outstanding;

    int                            beats_sent;
    logic                          holding_off;
    logic                          quiet_stretch;
    logic                          restart_needed;
    int                            cols_in_use;

    bilinear_grid_upsample_2x_unit i_dut (.*);

    bgu2x_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("bilinear_grid_upsample_2x_unit: mismatch");
        $finish;
    end

    // Result-side back-pressure: random stalls, plus the long hold-off when asked.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall <= holding_off || (!quiet_stretch && ($urandom_range(0, 99) < 8));
        end
    end

    // A long receiver hold-off early on, later a stretch with no idling on either side.
    initial
    begin
        holding_off   = 1'b0;
        quiet_stretch = 1'b0;
        wait (beats_sent >= 40);
        @(posedge clk);
        holding_off = 1'b1;
        repeat (300) @(posedge clk);
        holding_off = 1'b0;
        wait (beats_sent >= 250);
        @(posedge clk);
        quiet_stretch = 1'b1;
        wait (beats_sent >= 400);
        @(posedge clk);
        quiet_stretch = 1'b0;
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic signed [SAMPLE_BITS-1:0] s;
        case ($urandom_range(0, 7))
            0:       s = SAMPLE_MAX;
            1:       s = SAMPLE_MIN;
            2:       s = $urandom_range(0, 16) - 8;
            default: s = $urandom;
        endcase
        return s;
    endfunction

    // Offer one sample beat, with random gaps ahead of it, and wait until it is taken.
    task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] s, input logic gs);
        begin
            @(negedge clk);
            while (!quiet_stretch && ($urandom_range(0, 99) < 8))
            begin
                sample_valid <= 1'b0;
                @(negedge clk);
            end
            sample_valid <= 1'b1;
            sample       <= s;
            grid_start   <= gs || restart_needed;
            restart_needed = 1'b0;
            @(posedge clk);
            while (sample_stall) @(posedge clk);
            beats_sent++;
        end
    endtask

    // Stop offering beats and let every owed point come out.
    task automatic drain();
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
            wait (outstanding == 0);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [SIZE_BITS-1:0] data);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // Set a new grid size while idle. A grid that gets wider restarts at its origin,
    // so that no row above is ever read from a column that was never filled.
    task automatic apply_size(input logic [SIZE_BITS-1:0] cols, input logic [SIZE_BITS-1:0] rows);
        int eff;
        begin
            drain();
            write_reg(REG_GRID_COLUMNS, cols);
            write_reg(REG_GRID_ROWS, rows);
            eff = (cols < 2) ? 2 : ((cols > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols));
            if (eff > cols_in_use)
            begin
                restart_needed = 1'b1;
            end
            cols_in_use = eff;
        end
    endtask

    initial
    begin
        logic [SIZE_BITS-1:0] cols;
        logic [SIZE_BITS-1:0] rows;
        int                   count;

        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        sample         = '0;
        grid_start     = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_GRID_COLUMNS;
        cfg_data       = '0;
        beats_sent     = 0;
        cols_in_use    = MAX_COLUMNS;
        restart_needed = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset sizes: a few beats along row zero, small and extreme values.
        send_beat('0, 1'b1);
        send_beat(-1, 1'b0);
        send_beat(1, 1'b0);
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(SAMPLE_MIN, 1'b0);

        // Narrower grid while the position sits past the new width; rows above range.
        apply_size(SIZE_BITS'(3), SIZE_BITS'(2047));
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(SAMPLE_MIN, 1'b0);
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(SAMPLE_MIN, 1'b0);
        send_beat(SAMPLE_MIN, 1'b0);

        // Both sizes below range, row held past the end; then full 2x2 grids of extremes.
        apply_size(SIZE_BITS'(1), SIZE_BITS'(0));
        write_reg(UNUSED_REG_INDEX, SIZE_BITS'(5));
        send_beat(SAMPLE_MIN, 1'b0);
        send_beat(SAMPLE_MIN, 1'b0);
        repeat (4) send_beat(SAMPLE_MAX, 1'b0);
        repeat (4) send_beat(SAMPLE_MIN, 1'b0);

        // Full width along row zero; the long receiver hold-off falls in this stretch.
        apply_size(SIZE_BITS'(MAX_COLUMNS), SIZE_BITS'(2));
        repeat (64) send_beat(pick_sample(), 1'b0);

        // Random phases, mostly small grids so that rows and grids wrap often.
        while (beats_sent < 480)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       cols = SIZE_BITS'(0);
                    1:       cols = SIZE_BITS'(1);
                    2:       cols = SIZE_BITS'(MAX_COLUMNS + 1);
                    default: cols = SIZE_BITS'(2047);
                endcase
            end
            else
            begin
                cols = SIZE_BITS'($urandom_range(2, 6));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       rows = SIZE_BITS'(0);
                    1:       rows = SIZE_BITS'(1);
                    2:       rows = SIZE_BITS'(MAX_ROWS);
                    default: rows = SIZE_BITS'(2047);
                endcase
            end
            else
            begin
                rows = SIZE_BITS'($urandom_range(2, 5));
            end
            apply_size(cols, rows);
            count = $urandom_range(4, 36);
            repeat (count) send_beat(pick_sample(), $urandom_range(0, 15) == 0);
        end

        // Wait out the tail and watch for stray result beats.
        drain();
        repeat (16) @(negedge clk);
        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("bilinear_grid_upsample_2x_unit: match");
        end
        else
        begin
            $display("bilinear_grid_upsample_2x_unit: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/bgu2x_pkg.sv
rtl/core/bilinear_grid_upsample_2x_unit.sv
tb/sv/bgu2x_checker.sv
tb/sv/tb_bilinear_grid_upsample_2x_unit.sv
